### rtl/assert_macros.svh
// assertion helper macros for the marquee sequencer rtl
// no dependencies; included by marquee_scroll_sequencer, which checks its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge, off while reset is held
`define ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// same, with the consequent checked in the next cycle
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### rtl/mqs_pkg.sv
// shared types and constants for the marquee scroll sequencer
// no dependencies; used by marquee_scroll_sequencer
package mqs_pkg;

    localparam int OFFSET_BITS = 12;
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

    localparam logic [15:0] START_DELAY_RST   = 16'd900;
    localparam logic [15:0] END_HOLD_RST      = 16'd1200;
    localparam logic [15:0] STEP_INTERVAL_RST = 16'd60;
    localparam logic [7:0]  STEP_PIXELS_RST   = 8'd2;

    typedef logic [OFFSET_BITS-1:0] t_off;
    typedef logic [OFFSET_BITS:0]   t_off_sum;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_WAIT   = 2'd1,
        PH_SCROLL = 2'd2,
        PH_HOLD   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_REPORT = 2'd1,
        OP_RESET  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        REG_START_DELAY   = 2'd0,
        REG_END_HOLD      = 2'd1,
        REG_STEP_INTERVAL = 2'd2,
        REG_STEP_PIXELS   = 2'd3
    } t_reg;

endpackage

### rtl/marquee_scroll_sequencer.sv
// Marquee scroll sequencer: one request per cycle while the result side keeps up,
// each answered by exactly one result in the next cycle. A request is a millisecond
// tick, an overflow report or a reset (tuser); the result carries the scroll offset,
// the phase and a redraw flag. All state updates happen in one combinational pass from
// the state registers to the result register, so a new request is taken every cycle
// while the result side keeps up; when the result register is held by a stalled
// consumer, input is held off until it drains. No clearing pass after reset.
// depends on mqs_pkg and assert_macros.svh
`include "assert_macros.svh"

module marquee_scroll_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    // request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [11:0] overflow_px, [15:12] zero
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] op
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [11:0] scroll_offset, [13:12] phase_now,
                                          // [14] redraw, [15] zero
);

    logic [15:0] r_start_delay;
    logic [15:0] r_end_hold;
    logic [15:0] r_step_interval;
    logic [7:0]  r_step_pixels;

    mqs_pkg::t_phase r_phase, n_phase;
    mqs_pkg::t_off   r_offset, n_offset;
    mqs_pkg::t_off   r_overflow, n_overflow;
    logic            r_armed, n_armed;
    logic [15:0]     r_countdown, n_countdown;
    logic            n_redraw;

    logic            r_out_valid;
    logic [15:0]     r_out_data, n_out_data;

    logic            accept;
    mqs_pkg::t_off   px_sat;
    mqs_pkg::t_off_sum step_sum;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_delay   <= mqs_pkg::START_DELAY_RST;
            r_end_hold      <= mqs_pkg::END_HOLD_RST;
            r_step_interval <= mqs_pkg::STEP_INTERVAL_RST;
            r_step_pixels   <= mqs_pkg::STEP_PIXELS_RST;
        end else if (i_cfg_we) begin
            unique case (mqs_pkg::t_reg'(i_cfg_idx))
                mqs_pkg::REG_START_DELAY:   r_start_delay   <= i_cfg_wdata;
                mqs_pkg::REG_END_HOLD:      r_end_hold      <= i_cfg_wdata;
                mqs_pkg::REG_STEP_INTERVAL: r_step_interval <= i_cfg_wdata;
                mqs_pkg::REG_STEP_PIXELS:   r_step_pixels   <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // overflow report saturates at what the offset register can hold
    assign px_sat = ({4'b0, i_s_axis_tdata[11:0]} > 16'(mqs_pkg::OFFSET_MAX))
                    ? mqs_pkg::OFFSET_MAX : mqs_pkg::t_off'(i_s_axis_tdata[11:0]);

    assign step_sum = {1'b0, r_offset} + mqs_pkg::t_off_sum'(r_step_pixels);

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_offset    = r_offset;
        n_overflow  = r_overflow;
        n_armed     = r_armed;
        n_countdown = r_countdown;
        n_redraw    = 1'b0;
        case (mqs_pkg::t_op'(i_s_axis_tuser))
            mqs_pkg::OP_TICK: begin
                if (r_armed) begin
                    if (r_countdown <= 16'd1) begin
                        // expiry: disarm, then the phase may re-arm
                        n_armed     = 1'b0;
                        n_countdown = '0;
                        unique case (r_phase)
                            mqs_pkg::PH_WAIT, mqs_pkg::PH_SCROLL: begin
                                n_redraw = 1'b1;
                                n_armed  = 1'b1;
                                if (step_sum >= {1'b0, r_overflow}) begin
                                    n_offset    = r_overflow;
                                    n_phase     = mqs_pkg::PH_HOLD;
                                    n_countdown = r_end_hold;
                                end else begin
                                    n_offset    = step_sum[mqs_pkg::OFFSET_BITS-1:0];
                                    n_phase     = mqs_pkg::PH_SCROLL;
                                    n_countdown = r_step_interval;
                                end
                            end
                            mqs_pkg::PH_HOLD: begin
                                n_redraw    = 1'b1;
                                n_armed     = 1'b1;
                                n_offset    = '0;
                                n_phase     = mqs_pkg::PH_WAIT;
                                n_countdown = r_start_delay;
                            end
                            default: ;
                        endcase
                    end else begin
                        n_countdown = r_countdown - 16'd1;
                    end
                end
            end
            mqs_pkg::OP_REPORT: begin
                n_overflow = px_sat;
                if (px_sat == '0) begin
                    if (r_phase != mqs_pkg::PH_IDLE) begin
                        n_phase     = mqs_pkg::PH_IDLE;
                        n_offset    = '0;
                        n_armed     = 1'b0;
                        n_countdown = '0;
                    end
                end else if (r_phase == mqs_pkg::PH_IDLE) begin
                    n_phase     = mqs_pkg::PH_WAIT;
                    n_armed     = 1'b1;
                    n_countdown = r_start_delay;
                end
            end
            mqs_pkg::OP_RESET: begin
                n_phase     = mqs_pkg::PH_IDLE;
                n_offset    = '0;
                n_overflow  = '0;
                n_armed     = 1'b0;
                n_countdown = '0;
            end
            default: ;
        endcase
    end

    // result payload
    always_comb begin
        n_out_data        = '0;
        n_out_data[11:0]  = 12'(n_offset);
        n_out_data[13:12] = n_phase;
        n_out_data[14]    = n_redraw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= mqs_pkg::PH_IDLE;
            r_offset    <= '0;
            r_overflow  <= '0;
            r_armed     <= 1'b0;
            r_countdown <= '0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_offset    <= n_offset;
            r_overflow  <= n_overflow;
            r_armed     <= n_armed;
            r_countdown <= n_countdown;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    // the timer runs exactly when the sequence is active
    `ASSERT_IMPL(a_armed_active, 1'b1, r_armed == (r_phase != mqs_pkg::PH_IDLE),
        "timer armed state disagrees with phase")
    `ASSERT_IMPL(a_idle_zero, r_phase == mqs_pkg::PH_IDLE, r_offset == '0,
        "nonzero offset while idle")
    `ASSERT_IMPL(a_no_overrun, r_out_valid && !i_m_axis_tready, !o_s_axis_tready,
        "request taken while result is stalled")
    `ASSERT_NEXT(a_result_follows, accept, r_out_valid,
        "accepted request produced no result")

endmodule
